[design/pgm_sp_pkg.sv]
// shared types, character codes and helpers for the pgm stream parser
package pgm_sp_pkg;

  localparam int unsigned ACC_W = 16;
  localparam int unsigned IDX_W = 20;

  localparam logic [ACC_W-1:0] ACC_MAX = 16'hFFFF;
  localparam logic [7:0]       GRAY_MAX = 8'd255;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    ST_BUSY   = 4'd0,
    ST_DONE   = 4'd1,
    ST_MAGIC  = 4'd2,
    ST_WIDTH  = 4'd3,
    ST_HEIGHT = 4'd4,
    ST_MAXVAL = 4'd5,
    ST_RANGE  = 4'd6,
    ST_SHORT  = 4'd7,
    ST_ASCII  = 4'd8
  } status_e;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[design/pgm_stream_parser.sv]
// pgm stream parser: byte-serial p2/p5 header check and pixel decode
// the result of an accepted byte is registered and appears on the master side in the next cycle
// throughput: one byte per cycle while the master side takes results
// each byte is handled in one pass of the parse logic into the result register, a last byte in a second
// pass for the end of stream; rst_ni (async, active low) empties the result register and sets the parser to
// expect the first magic byte with busy status
module pgm_stream_parser #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // first_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // pixel_value, pixel_index, parse_status,
                                        // image_width, image_height, max_gray,
                                        // binary_format, zero pad
  output logic        m_axis_tuser_o    // pixel_valid
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW = pgm_sp_pkg::ACC_W;
  localparam int unsigned IW = pgm_sp_pkg::IDX_W;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_PIX5,
    PH_PIX2,
    PH_END
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    pgm_sp_pkg::status_e status;
    logic                in_comment;
    logic                in_number;
    logic                negative;
    logic                digits_seen;
    logic                is_binary;
    logic                header_ok;
    logic [AW-1:0]       acc;
    logic [AW-1:0]       width;
    logic [AW-1:0]       height;
    logic [7:0]          maxval;
    logic [IW-1:0]       pix_cnt;
    logic [CW-1:0]       col;
    logic [RW-1:0]       row;
  } parse_st_t;

  typedef struct packed {
    parse_st_t     st;
    logic          pix_vld;
    logic [7:0]    pix_val;
    logic [IW-1:0] pix_idx;
  } work_t;

  function automatic parse_st_t init_state();
    parse_st_t s;
    s.phase       = PH_MAGIC0;
    s.status      = pgm_sp_pkg::ST_BUSY;
    s.in_comment  = 1'b0;
    s.in_number   = 1'b0;
    s.negative    = 1'b0;
    s.digits_seen = 1'b0;
    s.is_binary   = 1'b0;
    s.header_ok   = 1'b0;
    s.acc         = '0;
    s.width       = '0;
    s.height      = '0;
    s.maxval      = '0;
    s.pix_cnt     = '0;
    s.col         = '0;
    s.row         = '0;
    return s;
  endfunction

  function automatic work_t fail(work_t w, pgm_sp_pkg::status_e code);
    work_t r;
    r = w;
    r.st.status = code;
    r.st.phase  = PH_END;
    return r;
  endfunction

  function automatic work_t add_digit(work_t w, logic [7:0] c);
    work_t      r;
    logic [AW+3:0] v;
    r = w;
    // acc*10 + digit, saturating
    v = ({4'b0, w.st.acc} << 3) + ({4'b0, w.st.acc} << 1) + {{AW{1'b0}}, c[3:0]};
    r.st.acc = (v > {4'b0, pgm_sp_pkg::ACC_MAX}) ? pgm_sp_pkg::ACC_MAX : v[AW-1:0];
    r.st.digits_seen = 1'b1;
    return r;
  endfunction

  function automatic work_t clear_number(work_t w);
    work_t r;
    r = w;
    r.st.in_number   = 1'b0;
    r.st.negative    = 1'b0;
    r.st.digits_seen = 1'b0;
    r.st.acc         = '0;
    return r;
  endfunction

  function automatic work_t field_start(work_t w, logic [7:0] c, logic eos, logic cmt_ok,
                                       pgm_sp_pkg::status_e err);
    work_t r;
    r = w;
    if (eos || !pgm_sp_pkg::is_space(c)) begin
      if (!eos && cmt_ok && (c == pgm_sp_pkg::CH_HASH)) begin
        r.st.in_comment = 1'b1;
      end else if (!eos && ((c == pgm_sp_pkg::CH_PLUS) || (c == pgm_sp_pkg::CH_MINUS))) begin
        r.st.in_number = 1'b1;
        r.st.negative  = (c == pgm_sp_pkg::CH_MINUS);
      end else if (!eos && pgm_sp_pkg::is_digit(c)) begin
        r.st.in_number = 1'b1;
        r = add_digit(r, c);
      end else begin
        r = fail(r, err);
      end
    end
    return r;
  endfunction

  function automatic work_t emit_pixel(work_t w, logic [7:0] value);
    work_t r;
    logic  col_last;
    logic  row_last;
    r = w;
    r.pix_vld    = 1'b1;
    r.pix_val    = value;
    r.pix_idx    = w.st.pix_cnt;
    r.st.pix_cnt = w.st.pix_cnt + IW'(1);
    col_last = (AW'(w.st.col) == (w.st.width - AW'(1)));
    row_last = (AW'(w.st.row) == (w.st.height - AW'(1)));
    // raster position tracks completion so no w*h product is needed
    if (col_last && row_last) begin
      r.st.status = pgm_sp_pkg::ST_DONE;
      r.st.phase  = PH_END;
    end else if (col_last) begin
      r.st.col = '0;
      r.st.row = w.st.row + RW'(1);
    end else begin
      r.st.col = w.st.col + CW'(1);
    end
    return r;
  endfunction

  function automatic pgm_sp_pkg::status_e field_err(phase_e ph);
    pgm_sp_pkg::status_e e;
    unique case (ph)
      PH_WIDTH:  e = pgm_sp_pkg::ST_WIDTH;
      PH_HEIGHT: e = pgm_sp_pkg::ST_HEIGHT;
      PH_MAXVAL: e = pgm_sp_pkg::ST_MAXVAL;
      PH_PIX5:   e = pgm_sp_pkg::ST_SHORT;
      PH_PIX2:   e = pgm_sp_pkg::ST_ASCII;
      default:   e = pgm_sp_pkg::ST_MAGIC;
    endcase
    return e;
  endfunction

  // one pass over a byte, or over the end of the stream when eos is set
  function automatic work_t feed(work_t w, logic [7:0] c, logic eos);
    work_t               r;
    pgm_sp_pkg::status_e err;
    logic [AW-1:0]       val;
    logic                range_ok;
    r        = w;
    err      = field_err(w.st.phase);
    val      = w.st.negative ? '0 : w.st.acc;
    range_ok = (val >= AW'(1)) && (val <= AW'(pgm_sp_pkg::GRAY_MAX)) &&
               (w.st.width >= AW'(1)) && (w.st.width <= AW'(MAX_WIDTH)) &&
               (w.st.height >= AW'(1)) && (w.st.height <= AW'(MAX_HEIGHT));
    unique case (w.st.phase)
      PH_MAGIC0: begin
        if (!eos && (c == pgm_sp_pkg::CH_P)) begin
          r.st.phase = PH_MAGIC1;
        end else begin
          r = fail(r, pgm_sp_pkg::ST_MAGIC);
        end
      end
      PH_MAGIC1: begin
        if (!eos && ((c == pgm_sp_pkg::CH_5) || (c == pgm_sp_pkg::CH_2))) begin
          r.st.is_binary = (c == pgm_sp_pkg::CH_5);
          r.st.phase     = PH_WIDTH;
        end else begin
          r = fail(r, pgm_sp_pkg::ST_MAGIC);
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (w.st.in_comment) begin
          if (!eos && (c == pgm_sp_pkg::CH_NL)) begin
            r.st.in_comment = 1'b0;
          end
        end else if (!w.st.in_number) begin
          r = field_start(r, c, eos, 1'b1, err);
        end else if (!eos && pgm_sp_pkg::is_digit(c)) begin
          r = add_digit(r, c);
        end else if (!w.st.digits_seen) begin
          r = fail(r, err);
        end else begin
          // the ending byte starts the next field, or is the p5 separator
          r = clear_number(r);
          unique case (w.st.phase)
            PH_WIDTH: begin
              r.st.width = val;
              r.st.phase = PH_HEIGHT;
              r = field_start(r, c, eos, 1'b1, pgm_sp_pkg::ST_HEIGHT);
            end
            PH_HEIGHT: begin
              r.st.height = val;
              r.st.phase  = PH_MAXVAL;
              r = field_start(r, c, eos, 1'b1, pgm_sp_pkg::ST_MAXVAL);
            end
            default: begin
              if (!range_ok) begin
                r = fail(r, pgm_sp_pkg::ST_RANGE);
              end else begin
                r.st.maxval    = val[7:0];
                r.st.header_ok = 1'b1;
                r.st.pix_cnt   = '0;
                r.st.col       = '0;
                r.st.row       = '0;
                if (w.st.is_binary) begin
                  // this byte was the separator
                  r.st.phase = PH_PIX5;
                end else begin
                  r.st.phase = PH_PIX2;
                  r = field_start(r, c, eos, 1'b0, pgm_sp_pkg::ST_ASCII);
                end
              end
            end
          endcase
        end
      end
      PH_PIX5: begin
        if (!eos) begin
          r = emit_pixel(r, c);
        end
      end
      PH_PIX2: begin
        if (!w.st.in_number) begin
          r = field_start(r, c, eos, 1'b0, pgm_sp_pkg::ST_ASCII);
        end else if (!eos && pgm_sp_pkg::is_digit(c)) begin
          r = add_digit(r, c);
        end else if (!w.st.digits_seen) begin
          r = fail(r, pgm_sp_pkg::ST_ASCII);
        end else begin
          r = clear_number(r);
          r = emit_pixel(r, (val > AW'(pgm_sp_pkg::GRAY_MAX)) ? pgm_sp_pkg::GRAY_MAX
                                                              : val[7:0]);
          if (r.st.phase == PH_PIX2) begin
            r = field_start(r, c, eos, 1'b0, pgm_sp_pkg::ST_ASCII);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  parse_st_t     state_q;
  logic          out_vld_q;
  logic [63:0]   out_data_q;
  logic          out_user_q;

  work_t         w0;
  work_t         w1;
  work_t         w2;
  logic          accept;
  logic [63:0]   out_data_d;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    w0.st      = s_axis_tuser_i ? init_state() : state_q;
    w0.pix_vld = 1'b0;
    w0.pix_val = '0;
    w0.pix_idx = '0;
    w1 = (w0.st.status == pgm_sp_pkg::ST_BUSY) ? feed(w0, s_axis_tdata_i, 1'b0) : w0;
    w2 = w1;
    if (s_axis_tlast_i && (w1.st.status == pgm_sp_pkg::ST_BUSY)) begin
      w2 = feed(w1, s_axis_tdata_i, 1'b1);
      if (w2.st.status == pgm_sp_pkg::ST_BUSY) begin
        w2 = fail(w2, field_err(w2.st.phase));
      end
    end
  end

  always_comb begin
    out_data_d = {1'b0,
                  w2.st.is_binary,
                  w2.st.header_ok ? w2.st.maxval      : 8'd0,
                  w2.st.header_ok ? w2.st.height[10:0] : 11'd0,
                  w2.st.header_ok ? w2.st.width[10:0]  : 11'd0,
                  w2.st.status,
                  w2.pix_idx,
                  w2.pix_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= init_state();
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_user_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q    <= w2.st;
        out_data_q <= out_data_d;
        out_user_q <= w2.pix_vld;
      end
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
